// ===== hdl/madc_pkg.sv =====
// Shared types, register indexes and arithmetic helpers of the motor ADC current conditioner.
`timescale 1ns / 1ps

package madc_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_AUTO_ZERO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUS_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VOLT_MULT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VOLT_BIAS  = 3'd4;

	localparam logic [15:0] GAIN_RESET = 16'd256;

	localparam int NCH    = 3;
	localparam int CH_U   = 0;
	localparam int CH_V   = 1;
	localparam int CH_BUS = 2;

	localparam int OUT_DEPTH = 16;
	localparam int OUT_CNT_W = 5;

	localparam logic signed [13:0] LP_ALPHA = 14'sd3277;

	typedef struct packed {
		logic        [15:0] phase_gain;
		logic        [15:0] bus_gain;
		logic        [15:0] volt_mult;
		logic signed [15:0] volt_bias;
	} scale_cfg_t;

	typedef struct packed {
		logic signed [15:0] bus_current_filtered;
		logic signed [15:0] phase_u_current;
		logic signed [15:0] phase_v_current;
		logic signed [15:0] phase_w_current;
		logic signed [15:0] bus_voltage_filtered;
	} result_t;

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		logic signed [15:0] r;
		if (v > 48'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -48'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/madc_ring.sv =====
// Sample rings in one memory, running sums, ring-average divider and offset registers.
`timescale 1ns / 1ps

module madc_ring #(
	parameter int RING_DEPTH  = 64,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          push,
	input  logic                                          auto_zero,
	input  logic [madc_pkg::NCH-1:0][SAMPLE_BITS-1:0]     samp_in,
	input  logic [SAMPLE_BITS-1:0]                        vbus_in,
	output logic                                          valid_o,
	output logic [madc_pkg::NCH-1:0][SAMPLE_BITS-1:0]     samp_o,
	output logic [madc_pkg::NCH-1:0][SAMPLE_BITS-1:0]     off_o,
	output logic [SAMPLE_BITS-1:0]                        vbus_o
);
	import madc_pkg::*;

	localparam int PW   = $clog2(RING_DEPTH);
	localparam int SUMW = SAMPLE_BITS + PW;
	localparam int PDW  = 2 * SUMW;
	localparam logic [SUMW-1:0] RECIP    = SUMW'((64'd1 << SUMW) / RING_DEPTH);
	localparam logic [SUMW-1:0] DEPTH_C  = SUMW'(RING_DEPTH);
	localparam logic [SUMW-1:0] REM_LIM  = SUMW'(2 * RING_DEPTH);
	localparam logic [SUMW-1:0] SUM_MAX  = SUMW'(((1 << SAMPLE_BITS) - 1) * RING_DEPTH);
	localparam logic [PW-1:0]   POS_LAST = PW'(RING_DEPTH - 1);
	localparam logic [SAMPLE_BITS-1:0] MID = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [NCH-1:0][SAMPLE_BITS-1:0] mem [RING_DEPTH];

	logic [PW-1:0] pos_q;
	logic          filled_q;
	logic          v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [NCH-1:0][SAMPLE_BITS-1:0] old_s1, samp_s1, samp_s2, samp_s3, samp_s4, samp_s5;
	logic [SAMPLE_BITS-1:0]          vbus_s1, vbus_s2, vbus_s3, vbus_s4, vbus_s5;
	logic                            filled_s1;

	logic [NCH-1:0][SUMW-1:0]        sum_q, sum_nx, sum_s2, sum_s3, sum_s4;
	logic [NCH-1:0][PDW-1:0]         prod_s3;
	logic [NCH-1:0][SAMPLE_BITS-1:0] q0, q0_s4, q, off_nx, off_q, off_s5;
	logic [NCH-1:0][SUMW-1:0]        qd, qd_s4, rem;
	logic [NCH-1:0][SAMPLE_BITS-1:0] old_eff;
	logic                            sum_ok, rem_ok;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[pos_q] <= samp_in;
			old_s1     <= mem[pos_q];
		end
	end

	always_comb begin
		sum_ok = 1'b1;
		rem_ok = 1'b1;
		for (int c = 0; c < NCH; c++) begin
			old_eff[c] = filled_s1 ? old_s1[c] : '0;
			sum_nx[c]  = sum_q[c] - SUMW'(old_eff[c]) + SUMW'(samp_s1[c]);
			q0[c]      = prod_s3[c][SUMW +: SAMPLE_BITS];
			qd[c]      = SUMW'(q0[c]) * DEPTH_C;
			rem[c]     = sum_s4[c] - qd_s4[c];
			q[c]       = q0_s4[c] + SAMPLE_BITS'(rem[c] >= DEPTH_C);
			off_nx[c]  = auto_zero ? q[c] : off_q[c];
			if (sum_q[c] > SUM_MAX) begin
				sum_ok = 1'b0;
			end
			if (rem[c] >= REM_LIM) begin
				rem_ok = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		samp_s1   <= samp_in;
		vbus_s1   <= vbus_in;
		filled_s1 <= filled_q;
		samp_s2   <= samp_s1;
		vbus_s2   <= vbus_s1;
		sum_s2    <= sum_nx;
		samp_s3   <= samp_s2;
		vbus_s3   <= vbus_s2;
		sum_s3    <= sum_s2;
		for (int c = 0; c < NCH; c++) begin
			prod_s3[c] <= PDW'(sum_s2[c]) * PDW'(RECIP);
		end
		samp_s4   <= samp_s3;
		vbus_s4   <= vbus_s3;
		sum_s4    <= sum_s3;
		q0_s4     <= q0;
		qd_s4     <= qd;
		samp_s5   <= samp_s4;
		vbus_s5   <= vbus_s4;
		off_s5    <= off_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			filled_q <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			sum_q    <= '0;
			off_q    <= {NCH{MID}};
		end else begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (push) begin
				if (pos_q == POS_LAST) begin
					pos_q    <= '0;
					filled_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (v_s1) begin
				sum_q <= sum_nx;
			end
			if (v_s4) begin
				off_q <= off_nx;
			end
		end
	end

	assign valid_o = v_s5;
	assign samp_o  = samp_s5;
	assign off_o   = off_s5;
	assign vbus_o  = vbus_s5;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n) pos_q <= POS_LAST)
		else $error("ring position out of range");
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n) v_s2 |-> sum_ok)
		else $error("running sum exceeds full ring of full-scale samples");
	a_div_fix: assert property (@(posedge clk) disable iff (!arst_n) v_s4 |-> rem_ok)
		else $error("reciprocal quotient off by more than one");

endmodule

// ===== hdl/madc_scale.sv =====
// Gain scaling, saturation, phase W derivation and low-pass filters.
`timescale 1ns / 1ps

module madc_scale #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      valid_i,
	input  logic [madc_pkg::NCH-1:0][SAMPLE_BITS-1:0] samp_i,
	input  logic [madc_pkg::NCH-1:0][SAMPLE_BITS-1:0] off_i,
	input  logic [SAMPLE_BITS-1:0]                    vbus_i,
	input  madc_pkg::scale_cfg_t                      cfg,
	output logic                                      valid_o,
	output madc_pkg::result_t                         res_o
);
	import madc_pkg::*;

	localparam int PRW = SAMPLE_BITS + 18;
	localparam int VPW = SAMPLE_BITS + 16;

	function automatic logic signed [31:0] lp_next(input logic signed [31:0] s,
		input logic signed [15:0] x);
		logic signed [47:0] d;
		logic signed [47:0] p;
		d = $signed({{16{x[15]}}, x, 16'h0000}) - 48'(s);
		p = d * 48'(LP_ALPHA);
		return s + p[47:16];
	endfunction

	logic                       v_s6, v_s7, v_s8;
	logic signed [SAMPLE_BITS:0] diff [NCH];
	logic signed [PRW-1:0]      diff_x [NCH];
	logic signed [PRW-1:0]      gain_x [NCH];
	logic signed [PRW-1:0]      prod_s6 [NCH];
	logic        [VPW-1:0]      vprod_s6;
	logic signed [15:0]         cur [NCH];
	logic signed [15:0]         cur_s7 [NCH];
	logic signed [47:0]         vsh_x, bias_x, uv_x;
	logic signed [15:0]         vb, vb_s7;
	logic signed [31:0]         lpb_q, lpv_q, lpb_nx, lpv_nx;
	result_t                    res_s8;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			diff[c]   = $signed({1'b0, samp_i[c]}) - $signed({1'b0, off_i[c]});
			diff_x[c] = PRW'(diff[c]);
			gain_x[c] = (c == CH_BUS) ? PRW'($signed({1'b0, cfg.bus_gain}))
			                          : PRW'($signed({1'b0, cfg.phase_gain}));
			cur[c]    = sat16(48'(prod_s6[c] >>> SAMPLE_BITS));
		end
		vsh_x  = $signed(48'(vprod_s6 >> 16));
		bias_x = 48'(cfg.volt_bias);
		vb     = sat16(vsh_x + bias_x);
		uv_x   = 48'(cur_s7[CH_U]) + 48'(cur_s7[CH_V]);
		lpb_nx = lp_next(lpb_q, cur_s7[CH_BUS]);
		lpv_nx = lp_next(lpv_q, vb_s7);
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			prod_s6[c] <= diff_x[c] * gain_x[c];
			cur_s7[c]  <= cur[c];
		end
		vprod_s6 <= VPW'(vbus_i) * VPW'(cfg.volt_mult);
		vb_s7    <= vb;
		res_s8.bus_current_filtered <= lpb_nx[31:16];
		res_s8.phase_u_current      <= cur_s7[CH_U];
		res_s8.phase_v_current      <= cur_s7[CH_V];
		res_s8.phase_w_current      <= sat16(-uv_x);
		res_s8.bus_voltage_filtered <= lpv_nx[31:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			lpb_q <= '0;
			lpv_q <= '0;
		end else begin
			v_s6 <= valid_i;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			if (v_s7) begin
				lpb_q <= lpb_nx;
				lpv_q <= lpv_nx;
			end
		end
	end

	assign valid_o = v_s8;
	assign res_o   = res_s8;

	a_lp_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |=> (lpb_q[31:16] == res_s8.bus_current_filtered) &&
		         (lpv_q[31:16] == res_s8.bus_voltage_filtered))
		else $error("filter output out of step with filter state");

endmodule

// ===== hdl/madc_fifo.sv =====
// Output queue that holds finished result items until the consumer takes them.
`timescale 1ns / 1ps

module madc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  madc_pkg::result_t din,
	input  logic              out_stall,
	output logic              out_valid,
	output madc_pkg::result_t dout
);
	import madc_pkg::*;

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(OUT_DEPTH - 1);

	result_t              mem [OUT_DEPTH];
	logic [PTR_W-1:0]     wr_q, rd_q;
	logic [OUT_CNT_W-1:0] fill_q;
	logic                 pop;

	assign out_valid = (fill_q != '0);
	assign pop       = out_valid && !out_stall;
	assign dout      = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fill_q < OUT_CNT_W'(OUT_DEPTH)) || pop)
		else $error("result pushed into full queue");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("queue fill count out of range");

endmodule

// ===== hdl/motor_adc_current_conditioner.sv =====
// Top level of the motor ADC current conditioner: registers, credit count and datapath.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+--------------------------------------------
//   cfg     | in  | cfg_we               | cfg_index, cfg_data
//   in      | in  | in_valid / in_stall  | bus_current_raw, phase_u_raw, phase_v_raw,
//           |     |                      | bus_voltage_raw
//   out     | out | out_valid / out_stall| bus_current_filtered, phase_u/v/w_current,
//           |     |                      | bus_voltage_filtered
//
// One item per cycle while in_stall is low; each accepted item passes the ring pipeline (s1 to s5), the scale
// pipeline (s6 to s8) and the output queue before its result is offered. The ring memory is read and written
// at the same address on accept (old value out), so consecutive items never contend for one entry.
// Reset clears the rings logically: entries read as zero until the position first wraps.
// in_stall rises when 16 items are accepted but not yet taken at the output.
`timescale 1ns / 1ps

module motor_adc_current_conditioner #(
	parameter int RING_DEPTH  = 64,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [madc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [madc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [SAMPLE_BITS-1:0]            bus_current_raw,
	input  logic [SAMPLE_BITS-1:0]            phase_u_raw,
	input  logic [SAMPLE_BITS-1:0]            phase_v_raw,
	input  logic [SAMPLE_BITS-1:0]            bus_voltage_raw,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [15:0]                bus_current_filtered,
	output logic signed [15:0]                phase_u_current,
	output logic signed [15:0]                phase_v_current,
	output logic signed [15:0]                phase_w_current,
	output logic signed [15:0]                bus_voltage_filtered
);
	import madc_pkg::*;

	logic                            auto_zero_q;
	scale_cfg_t                      cfg_q;
	logic [OUT_CNT_W-1:0]            cnt_q;
	logic                            in_acc, out_acc;
	logic [NCH-1:0][SAMPLE_BITS-1:0] samp_in, samp_r, off_r;
	logic [SAMPLE_BITS-1:0]          vbus_r;
	logic                            ring_valid, res_valid;
	result_t                         res, res_out;

	assign in_stall = (cnt_q == OUT_CNT_W'(OUT_DEPTH));
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;

	always_comb begin
		samp_in         = '0;
		samp_in[CH_U]   = phase_u_raw;
		samp_in[CH_V]   = phase_v_raw;
		samp_in[CH_BUS] = bus_current_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_zero_q      <= 1'b1;
			cfg_q.phase_gain <= GAIN_RESET;
			cfg_q.bus_gain   <= GAIN_RESET;
			cfg_q.volt_mult  <= GAIN_RESET;
			cfg_q.volt_bias  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AUTO_ZERO:  auto_zero_q      <= cfg_data[0];
				REG_PHASE_GAIN: cfg_q.phase_gain <= cfg_data;
				REG_BUS_GAIN:   cfg_q.bus_gain   <= cfg_data;
				REG_VOLT_MULT:  cfg_q.volt_mult  <= cfg_data;
				REG_VOLT_BIAS:  cfg_q.volt_bias  <= $signed(cfg_data);
				default:        auto_zero_q      <= auto_zero_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	madc_ring #(
		.RING_DEPTH  (RING_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc),
		.auto_zero (auto_zero_q),
		.samp_in   (samp_in),
		.vbus_in   (bus_voltage_raw),
		.valid_o   (ring_valid),
		.samp_o    (samp_r),
		.off_o     (off_r),
		.vbus_o    (vbus_r)
	);

	madc_scale #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_i (ring_valid),
		.samp_i  (samp_r),
		.off_i   (off_r),
		.vbus_i  (vbus_r),
		.cfg     (cfg_q),
		.valid_o (res_valid),
		.res_o   (res)
	);

	madc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.din       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.dout      (res_out)
	);

	assign bus_current_filtered = res_out.bus_current_filtered;
	assign phase_u_current      = res_out.phase_u_current;
	assign phase_v_current      = res_out.phase_v_current;
	assign phase_w_current      = res_out.phase_w_current;
	assign bus_voltage_filtered = res_out.bus_voltage_filtered;

endmodule
